// ===== rtl/tlnf_pkg.sv =====
`timescale 1ns / 1ps
package tlnf_pkg;

    // number field layout
    localparam int NUMBER_DIGITS = 6;
    localparam int COUNT_W       = 4 * NUMBER_DIGITS;

    // command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // back-end emit steps: digits, tab, first body byte, second body byte
    localparam int STEP_TAB   = NUMBER_DIGITS;
    localparam int STEP_BODY0 = NUMBER_DIGITS + 1;
    localparam int STEP_BODY1 = NUMBER_DIGITS + 2;
    localparam int STEP_W     = $clog2(NUMBER_DIGITS + 3);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUMBER_MODE   = 3'd0,
        CFG_SQUEEZE_BLANK = 3'd1,
        CFG_SHOW_ENDS     = 3'd2,
        CFG_SHOW_TABS     = 3'd3,
        CFG_SHOW_NONPRINT = 3'd4
    } t_cfg_idx;

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_END = 8'h20;
    localparam logic [7:0] CARET_OFS = 8'h40;

    // one classified input byte, ready for the back end
    typedef struct packed {
        logic                     num;   // emit line number prefix
        logic [COUNT_W-1:0]       digits;
        logic [NUMBER_DIGITS-1:0] lead;  // digit shown as leading space
        logic                     two;   // body has a second byte
        logic [7:0]               b0;
        logic [7:0]               b1;
    } t_cmd;

    // saturating bcd increment
    function automatic logic [COUNT_W-1:0] bcd_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        logic               full;
        logic               carry;
        logic [3:0]         d;
        r     = v;
        full  = 1'b1;
        carry = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (v[4*i +: 4] < 4'd9) full = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            d = v[4*i +: 4];
            if (carry) begin
                if (d >= 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = d + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return full ? v : r;
    endfunction

endpackage

// ===== rtl/tlnf_front.sv =====
`timescale 1ns / 1ps
module tlnf_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tlnf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlnf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_accept,
    input  logic [7:0]                       i_in_byte,
    input  logic                             i_file_start,
    output logic                             o_wr,
    output tlnf_pkg::t_cmd                   o_cmd
);
    import tlnf_pkg::*;

    logic [1:0]         r_number_mode;
    logic               r_squeeze_blank;
    logic               r_show_ends;
    logic               r_show_tabs;
    logic               r_show_nonprint;

    logic               r_at_ls;
    logic               r_blank;
    logic [COUNT_W-1:0] r_count;

    logic               n_at_ls;
    logic               n_blank;
    logic [COUNT_W-1:0] n_count;

    logic               at_ls;
    logic               blank;
    logic [COUNT_W-1:0] count_base;
    logic               is_nl;
    logic               drop;
    logic               num;
    logic               zero_run;
    logic [NUMBER_DIGITS-1:0] lead_mask;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_mode   <= 2'd0;
            r_squeeze_blank <= 1'b0;
            r_show_ends     <= 1'b0;
            r_show_tabs     <= 1'b0;
            r_show_nonprint <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUMBER_MODE:   r_number_mode   <= i_cfg_data;
                CFG_SQUEEZE_BLANK: r_squeeze_blank <= i_cfg_data[0];
                CFG_SHOW_ENDS:     r_show_ends     <= i_cfg_data[0];
                CFG_SHOW_TABS:     r_show_tabs     <= i_cfg_data[0];
                CFG_SHOW_NONPRINT: r_show_nonprint <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // line state after an optional file restart
    always_comb begin
        at_ls      = i_file_start | r_at_ls;
        blank      = i_file_start ? 1'b0 : r_blank;
        count_base = i_file_start ? COUNT_W'(1) : r_count;
        is_nl      = (i_in_byte == CH_NL);
    end

    // blank squeezing and numbering decision
    always_comb begin
        drop    = 1'b0;
        n_blank = blank;
        if (at_ls && r_squeeze_blank) begin
            if (is_nl) begin
                if (blank) drop = 1'b1;
                else       n_blank = 1'b1;
            end else begin
                n_blank = 1'b0;
            end
        end
        num = at_ls && !drop &&
              (r_number_mode[1] ? !is_nl : (r_number_mode == 2'd1));
        n_count = num ? bcd_inc(count_base) : count_base;
        n_at_ls = is_nl;
    end

    // leading zero mask of the number snapshot
    always_comb begin
        zero_run  = 1'b1;
        lead_mask = '0;
        for (int i = NUMBER_DIGITS - 1; i > 0; i--) begin
            zero_run     = zero_run & (count_base[4*i +: 4] == 4'd0);
            lead_mask[i] = zero_run;
        end
    end

    // body bytes
    always_comb begin
        o_cmd.num    = num;
        o_cmd.digits = count_base;
        o_cmd.lead   = lead_mask;
        o_cmd.two    = 1'b0;
        o_cmd.b0     = i_in_byte;
        o_cmd.b1     = CH_NL;
        if (is_nl) begin
            o_cmd.two = r_show_ends;
            o_cmd.b0  = r_show_ends ? CH_DOLLAR : CH_NL;
        end else if (i_in_byte == CH_TAB) begin
            if (r_show_tabs) begin
                o_cmd.two = 1'b1;
                o_cmd.b0  = CH_CARET;
                o_cmd.b1  = CH_I;
            end
        end else if (r_show_nonprint && i_in_byte < CH_CTRL_END) begin
            o_cmd.two = 1'b1;
            o_cmd.b0  = CH_CARET;
            o_cmd.b1  = i_in_byte + CARET_OFS;
        end else if (r_show_nonprint && i_in_byte == CH_DEL) begin
            o_cmd.two = 1'b1;
            o_cmd.b0  = CH_CARET;
            o_cmd.b1  = CH_QMARK;
        end
    end

    assign o_wr = i_accept && !drop;

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_ls <= 1'b1;
            r_blank <= 1'b0;
            r_count <= COUNT_W'(1);
        end else if (i_accept) begin
            r_at_ls <= n_at_ls;
            r_blank <= n_blank;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/tlnf_cmd_fifo.sv =====
`timescale 1ns / 1ps
module tlnf_cmd_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  tlnf_pkg::t_cmd                i_wr_cmd,
    input  logic                          i_rd,
    output tlnf_pkg::t_cmd                o_head,
    output logic                          o_full,
    output logic                          o_empty
);
    import tlnf_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr_ptr] <= i_wr_cmd;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (rd_en) r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (wr_en && !rd_en)      r_cnt <= r_cnt + QCNT_W'(1);
            else if (rd_en && !wr_en) r_cnt <= r_cnt - QCNT_W'(1);
        end
    end

endmodule

// ===== rtl/tlnf_back.sv =====
`timescale 1ns / 1ps
module tlnf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlnf_pkg::t_cmd i_head,
    input  logic           i_q_empty,
    output logic           o_q_rd,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_out_byte,
    output logic           o_last
);
    import tlnf_pkg::*;

    logic              r_started;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic [STEP_W-1:0] step;
    logic              emit;
    logic              last;
    logic [7:0]        byte_out;
    logic [3:0]        digit;
    logic              lead;

    // step of the current command
    assign step = r_started ? r_step
                            : (i_head.num ? STEP_W'(0) : STEP_W'(STEP_BODY0));
    assign emit = !i_q_empty && (!r_out_valid || i_pop);
    assign last = (step == STEP_W'(STEP_BODY1)) ||
                  ((step == STEP_W'(STEP_BODY0)) && !i_head.two);

    // digit select, most significant first
    always_comb begin
        digit = 4'd0;
        lead  = 1'b0;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (step == STEP_W'(NUMBER_DIGITS - 1 - i)) begin
                digit = i_head.digits[4*i +: 4];
                lead  = i_head.lead[i];
            end
        end
    end

    // output byte of this step
    always_comb begin
        if (step == STEP_W'(STEP_BODY1))     byte_out = i_head.b1;
        else if (step == STEP_W'(STEP_BODY0)) byte_out = i_head.b0;
        else if (step == STEP_W'(STEP_TAB))   byte_out = CH_TAB;
        else if (lead)                        byte_out = CH_SPACE;
        else byte_out = CH_ZERO + {4'd0, (digit > 4'd9) ? 4'd9 : digit};
    end

    assign o_q_rd = emit && last;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_step    <= '0;
        end else if (emit) begin
            r_started <= !last;
            r_step    <= step + STEP_W'(1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_out;
            r_out_last <= last;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

`ifndef SYNTHESIS
    // mid-command step stays inside the emit sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> r_step <= STEP_W'(STEP_BODY1))
        else $error("emit step out of range");

    // a command being emitted keeps its queue entry
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> !i_q_empty)
        else $error("command queue drained mid-command");

    // a stalled command keeps its place
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_started && !emit) |=> (r_started && $stable(r_step)))
        else $error("emit step moved while stalled");
`endif

endmodule

// ===== rtl/text_line_number_escape_filter.sv =====
`timescale 1ns / 1ps
// Text filter for a byte stream: optional six-digit line number and tab at each
// line start (all lines or nonblank only), blank-line squeezing, '$' before
// newlines, tab as ^I, and control bytes and DEL in caret form. Input bytes
// are classified on entry and queued (four commands deep); a back-end emitter
// writes one output byte per cycle into the output register while it is free
// or popped. A plain byte yields one output byte; input is taken every cycle
// while the queue has room. A numbered line's prefix adds seven output bytes
// and a caret or '$' form one, as the queue absorbs up to three more inputs.
// A squeezed blank line gives no output. After reset the block is ready at once.
module text_line_number_escape_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tlnf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlnf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_in_byte,
    input  logic                             i_file_start,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       o_out_byte,
    output logic                             o_last
);
    import tlnf_pkg::*;

    t_cmd wr_cmd;
    t_cmd head;
    logic wr;
    logic q_rd;
    logic q_empty;
    logic accept;

    assign accept = push && !full;

    // classify input transactions
    tlnf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .o_wr         (wr),
        .o_cmd        (wr_cmd)
    );

    // command queue
    tlnf_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_wr_cmd (wr_cmd),
        .i_rd     (q_rd),
        .o_head   (head),
        .o_full   (full),
        .o_empty  (q_empty)
    );

    // emit output bytes
    tlnf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_empty  (q_empty),
        .o_q_rd     (q_rd),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule
